### sv/lph_pkg.sv
// Package: shared constants and types for the linear probe hash table.
package lph_pkg;
  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned KEY_BYTES_MAX_DEF = 8;
  localparam logic [63:0] SEED = 64'd2166136261;
  localparam logic [63:0] MUL_BLOCK = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MUL_TAIL = 64'hd6e8feb86659fd93;
  localparam logic [9:0] LOAD_LIMIT_RST = 10'd768;

  typedef enum logic [1:0] {
    MODE_GET = 2'd0,
    MODE_SET = 2'd1,
    MODE_GET_INS = 2'd2,
    MODE_REMOVE = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL0, ST_MUL1, ST_MUL2, ST_MUL3, ST_FOLD,
    ST_READ, ST_CHECK, ST_CLEAR, ST_OUT
  } state_e;
endpackage

### sv/lph_if.sv
// Interfaces: request and response channels.
interface lph_req_if;
  logic valid;
  logic ready;
  logic [1:0] mode;
  logic [63:0] key_bytes;
  logic [3:0] key_length;
  logic [63:0] value_in;
  modport source(output valid, mode, key_bytes, key_length, value_in, input ready);
  modport sink(input valid, mode, key_bytes, key_length, value_in, output ready);
endinterface

interface lph_rsp_if;
  logic valid;
  logic ready;
  logic found;
  logic [63:0] value_out;
  logic refused;
  logic [10:0] live_count;
  modport source(output valid, found, value_out, refused, live_count, input ready);
  modport sink(input valid, found, value_out, refused, live_count, output ready);
endinterface

### sv/linear_probe_hash_table_top.sv
// Top level: hash table with linear probing in one slot memory.
// After reset a clearing pass walks the slot state, one slot a cycle, before the first
// word is taken. A request then passes the hash states (three 32x32 partial products,
// one a cycle, then the fold with a reciprocal multiply and the remainder that gives
// the home slot), then a read and a check state for each probed slot, as the read of
// the slot memory is registered, then an output state that presents the result. The
// next word is taken in the cycle after the result word leaves.
module linear_probe_hash_table_top #(
  parameter int unsigned CAPACITY = lph_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_BYTES_MAX = lph_pkg::KEY_BYTES_MAX_DEF
) (
  input logic clk_i,
  input logic rst_ni,
  input logic cfg_we_i,
  input logic [9:0] cfg_wdata_i,
  lph_req_if.sink req,
  lph_rsp_if.source rsp
);
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned SW = 2 + 4 + 32 + 64 + 64;
  localparam int unsigned NW = AW + 1;
  // ceil(2^(32+AW) / CAPACITY): exact quotient for every 32-bit hash
  localparam logic [32:0] RECIP =
    33'(((64'd1 << (32 + AW)) + 64'(CAPACITY) - 64'd1) / 64'(CAPACITY));

  lph_pkg::state_e state_q, state_d;
  logic [9:0] limit_q;
  logic [10:0] entries_q, tombs_q, entries_d, tombs_d;
  logic [1:0] mode_q;
  logic [63:0] key_q, val_q, h_q, prod_q;
  logic [3:0] len_q;
  logic [63:0] mul_a_q;
  logic [31:0] hash_q;
  logic [31:0] quot_q;
  logic [AW-1:0] idx_q, addr;
  logic [NW-1:0] cnt_q;
  logic found_q, refused_q;
  logic [63:0] vout_q;

  // slot word: {used, tomb, len, hash, key, value}
  logic [SW-1:0] mem [CAPACITY];
  logic [SW-1:0] rd_q, wr_data;
  logic wr_en;

  logic [3:0] len_c;
  logic [63:0] key_c, mixed_c;
  logic [31:0] pp;
  logic [AW-1:0] idx_next;
  logic s_used, s_tomb, hit, can_ins;
  logic [31:0] fold_c, rem_c;
  logic [64:0] recip_prod;

  always_comb begin
    len_c = (req.key_length > 4'(KEY_BYTES_MAX)) ? 4'(KEY_BYTES_MAX) : req.key_length;
    key_c = req.key_bytes;
    if (len_c < 4'd8) key_c = req.key_bytes & ((64'd1 << {len_c, 3'b000}) - 64'd1);
  end

  assign s_used = rd_q[SW-1];
  assign s_tomb = rd_q[SW-2];
  assign hit = s_used && !s_tomb && rd_q[SW-3 -: 4] == len_q &&
               rd_q[159:128] == hash_q && rd_q[127:64] == key_q;
  assign idx_next = (idx_q == AW'(CAPACITY - 1)) ? '0 : idx_q + 1'b1;
  assign can_ins = !s_used && ({1'b0, entries_q} + 12'd1 <= {2'b0, limit_q});

  // partial products of mixed word and multiplier, 32x32 each
  always_comb begin
    case (state_q)
      lph_pkg::ST_MUL0: pp = 32'(h_q[31:0] * mul_a_q[31:0]);
      lph_pkg::ST_MUL1: pp = 32'(h_q[63:32] * mul_a_q[31:0]);
      lph_pkg::ST_MUL2: pp = 32'(h_q[31:0] * mul_a_q[63:32]);
      default: pp = '0;
    endcase
  end

  logic [63:0] lo_prod;
  assign lo_prod = h_q[31:0] * mul_a_q[31:0];

  // home slot: hash minus quotient times capacity
  assign fold_c = prod_q[63:32] ^ prod_q[31:0];
  assign recip_prod = fold_c * RECIP;
  assign rem_c = hash_q - 32'(quot_q * CAPACITY);

  always_comb begin
    state_d = state_q;
    case (state_q)
      lph_pkg::ST_CLEAR: if (cnt_q == NW'(CAPACITY - 1)) state_d = lph_pkg::ST_IDLE;
      lph_pkg::ST_IDLE: if (req.valid) state_d = lph_pkg::ST_MUL0;
      lph_pkg::ST_MUL0: state_d = lph_pkg::ST_MUL1;
      lph_pkg::ST_MUL1: state_d = lph_pkg::ST_MUL2;
      lph_pkg::ST_MUL2: state_d = lph_pkg::ST_MUL3;
      lph_pkg::ST_MUL3: state_d = lph_pkg::ST_FOLD;
      lph_pkg::ST_FOLD: state_d = lph_pkg::ST_READ;
      lph_pkg::ST_READ: state_d = lph_pkg::ST_CHECK;
      lph_pkg::ST_CHECK: begin
        if (hit || !s_used || cnt_q == NW'(CAPACITY - 1)) state_d = lph_pkg::ST_OUT;
        else state_d = lph_pkg::ST_READ;
      end
      lph_pkg::ST_OUT: if (rsp.ready) state_d = lph_pkg::ST_IDLE;
      default: state_d = lph_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    wr_en = 1'b0;
    wr_data = rd_q;
    entries_d = entries_q;
    tombs_d = tombs_q;
    addr = idx_q;
    case (state_q)
      lph_pkg::ST_CLEAR: begin
        wr_en = 1'b1;
        wr_data = '0;
        addr = cnt_q[AW-1:0];
      end
      lph_pkg::ST_CHECK: begin
        if (hit) begin
          if (mode_q == lph_pkg::MODE_SET) begin
            wr_en = 1'b1;
            wr_data[63:0] = val_q;
          end else if (mode_q == lph_pkg::MODE_REMOVE) begin
            wr_en = 1'b1;
            wr_data[SW-2] = 1'b1;
            tombs_d = tombs_q + 11'd1;
          end
        end else if (!s_used && can_ins &&
                     (mode_q == lph_pkg::MODE_SET || mode_q == lph_pkg::MODE_GET_INS)) begin
          wr_en = 1'b1;
          wr_data = {1'b1, 1'b0, len_q, hash_q, key_q, val_q};
          entries_d = entries_q + 11'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[addr] <= wr_data;
    rd_q <= mem[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lph_pkg::ST_CLEAR;
      limit_q <= lph_pkg::LOAD_LIMIT_RST;
      entries_q <= '0;
      tombs_q <= '0;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      entries_q <= entries_d;
      tombs_q <= tombs_d;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      case (state_q)
        lph_pkg::ST_CLEAR: cnt_q <= cnt_q + 1'b1;
        lph_pkg::ST_FOLD: cnt_q <= '0;
        lph_pkg::ST_CHECK: cnt_q <= cnt_q + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      lph_pkg::ST_IDLE: begin
        mode_q <= req.mode;
        key_q <= key_c;
        len_q <= len_c;
        val_q <= req.value_in;
        if (len_c >= 4'd8) begin
          h_q <= lph_pkg::SEED ^ key_c;
          mul_a_q <= lph_pkg::MUL_BLOCK;
        end else if (len_c != 4'd0) begin
          h_q <= lph_pkg::SEED ^ ({key_c[55:0], 8'h00} | {60'd0, len_c});
          mul_a_q <= lph_pkg::MUL_TAIL;
        end else begin
          h_q <= lph_pkg::SEED;
          mul_a_q <= 64'd1;
        end
      end
      lph_pkg::ST_MUL0: prod_q <= lo_prod;
      lph_pkg::ST_MUL1: prod_q[63:32] <= prod_q[63:32] + pp;
      lph_pkg::ST_MUL2: prod_q[63:32] <= prod_q[63:32] + pp;
      lph_pkg::ST_MUL3: begin
        hash_q <= fold_c;
        quot_q <= 32'(recip_prod >> (32 + AW));
      end
      lph_pkg::ST_FOLD: idx_q <= rem_c[AW-1:0];
      lph_pkg::ST_CHECK: begin
        found_q <= hit;
        vout_q <= hit ? rd_q[63:0] : 64'd0;
        refused_q <= !hit && (mode_q == lph_pkg::MODE_SET ||
                     mode_q == lph_pkg::MODE_GET_INS) && !can_ins &&
                     (!s_used || cnt_q == NW'(CAPACITY - 1));
        if (!hit && s_used) idx_q <= idx_next;
      end
      default: ;
    endcase
  end

  assign req.ready = (state_q == lph_pkg::ST_IDLE);
  assign rsp.valid = (state_q == lph_pkg::ST_OUT);
  assign rsp.found = found_q;
  assign rsp.value_out = vout_q;
  assign rsp.refused = refused_q;
  assign rsp.live_count = entries_q - tombs_q;
endmodule
